// File: hw/rtl/assert_macros.svh
// assertion macros shared by the ir transmitter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk_i, off while rst_ni is low
`define IPDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define IPDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ipdt_pkg.sv
// types, constants and helpers of the ir pulse-distance transmitter
`default_nettype none

package ipdt_pkg;

  localparam int unsigned DurW    = 16;
  localparam int unsigned RepW    = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned BitPosW = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegLeadMark  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLeadSpace = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBitMark   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegZeroSpace = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOneSpace  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGap       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRepeats   = 3'd6;

  // reset values of the registers
  localparam logic [DurW-1:0] LeadMarkRst  = 16'd9000;
  localparam logic [DurW-1:0] LeadSpaceRst = 16'd4500;
  localparam logic [DurW-1:0] BitMarkRst   = 16'd562;
  localparam logic [DurW-1:0] ZeroSpaceRst = 16'd562;
  localparam logic [DurW-1:0] OneSpaceRst  = 16'd1687;
  localparam logic [DurW-1:0] GapRst       = 16'd40000;
  localparam logic [RepW-1:0] RepeatsRst   = 3'd2;

  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhLeadMark  = 3'd1,
    PhLeadSpace = 3'd2,
    PhBitMark   = 3'd3,
    PhBitSpace  = 3'd4,
    PhGap       = 3'd5
  } phase_e;

  typedef struct packed {
    logic [DurW-1:0] lead_mark;
    logic [DurW-1:0] lead_space;
    logic [DurW-1:0] bit_mark;
    logic [DurW-1:0] zero_space;
    logic [DurW-1:0] one_space;
    logic [DurW-1:0] gap;
    logic [RepW-1:0] repeats;
  } cfg_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic done_res;
    logic rejected;
  } result_t;

  function automatic logic [DurW-1:0] dur_min1(input logic [DurW-1:0] d);
    return (d == '0) ? DurW'(1) : d;
  endfunction

  function automatic logic [RepW-1:0] rep_min1(input logic [RepW-1:0] r);
    return (r == '0) ? RepW'(1) : r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ipdt_if.sv
// valid/ready channel interfaces of the ir transmitter
`default_nettype none

interface ipdt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [ipdt_pkg::WordW-1:0]   command_bits;

  modport source (output valid, output cmd, output command_bits, input ready);
  modport sink   (input valid, input cmd, input command_bits, output ready);
endinterface

interface ipdt_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic done_res;
  logic rejected;

  modport source (output valid, output carrier_on, output busy_res, output done_res,
                  output rejected, input ready);
  modport sink   (input valid, input carrier_on, input busy_res, input done_res,
                  input rejected, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ipdt_cfg_regs.sv
// timing and repeat registers of the ir transmitter
`default_nettype none

module ipdt_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ipdt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ipdt_pkg::CfgDatW-1:0]  cfg_data_i,
  output ipdt_pkg::cfg_t                     cfg_o
);

  ipdt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipdt_pkg::RegLeadMark:  cfg_d.lead_mark  = cfg_data_i;
        ipdt_pkg::RegLeadSpace: cfg_d.lead_space = cfg_data_i;
        ipdt_pkg::RegBitMark:   cfg_d.bit_mark   = cfg_data_i;
        ipdt_pkg::RegZeroSpace: cfg_d.zero_space = cfg_data_i;
        ipdt_pkg::RegOneSpace:  cfg_d.one_space  = cfg_data_i;
        ipdt_pkg::RegGap:       cfg_d.gap        = cfg_data_i;
        ipdt_pkg::RegRepeats:   cfg_d.repeats    = cfg_data_i[ipdt_pkg::RepW-1:0];
        default:                cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_mark  <= ipdt_pkg::LeadMarkRst;
      cfg_q.lead_space <= ipdt_pkg::LeadSpaceRst;
      cfg_q.bit_mark   <= ipdt_pkg::BitMarkRst;
      cfg_q.zero_space <= ipdt_pkg::ZeroSpaceRst;
      cfg_q.one_space  <= ipdt_pkg::OneSpaceRst;
      cfg_q.gap        <= ipdt_pkg::GapRst;
      cfg_q.repeats    <= ipdt_pkg::RepeatsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/ipdt_sequencer.sv
// frame phase sequencer: one item in, one result out, state updated per item
`default_nettype none

`include "assert_macros.svh"

module ipdt_sequencer #(
  parameter int unsigned COMMAND_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ipdt_pkg::cfg_t              cfg_i,
  input  wire logic                        item_valid_i,
  input  wire logic                        cmd_i,
  input  wire logic [ipdt_pkg::WordW-1:0]  command_bits_i,
  output ipdt_pkg::result_t                result_o
);

  localparam logic [ipdt_pkg::BitPosW-1:0] LastBit = ipdt_pkg::BitPosW'(COMMAND_BITS - 1);

  ipdt_pkg::phase_e                    phase_q, phase_d;
  logic [ipdt_pkg::DurW-1:0]           ticks_q, ticks_d;
  logic [ipdt_pkg::BitPosW-1:0]        bitpos_q, bitpos_d;
  logic [ipdt_pkg::RepW-1:0]           frames_q, frames_d;
  logic [ipdt_pkg::WordW-1:0]          word_q, word_d;

  logic                                cur_bit;
  logic                                expire;
  logic                                last_frame;
  logic [ipdt_pkg::RepW-1:0]           frames_inc;

  // bits past the stored word go out as zero
  assign cur_bit    = bitpos_q[ipdt_pkg::BitPosW-1] ? 1'b0
                    : word_q[bitpos_q[ipdt_pkg::BitPosW-2:0]];
  assign expire     = (ticks_q <= ipdt_pkg::DurW'(1));
  assign frames_inc = frames_q + ipdt_pkg::RepW'(1);
  assign last_frame = (frames_inc >= ipdt_pkg::rep_min1(cfg_i.repeats)) || (frames_inc == '0);

  // next state
  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    bitpos_d = bitpos_q;
    frames_d = frames_q;
    word_d   = word_q;
    if (item_valid_i) begin
      if (cmd_i) begin
        if (phase_q == ipdt_pkg::PhIdle) begin
          word_d   = command_bits_i;
          bitpos_d = '0;
          frames_d = '0;
          phase_d  = ipdt_pkg::PhLeadMark;
          ticks_d  = ipdt_pkg::dur_min1(cfg_i.lead_mark);
        end
      end else if (phase_q != ipdt_pkg::PhIdle) begin
        if (!expire) begin
          ticks_d = ticks_q - ipdt_pkg::DurW'(1);
        end else begin
          unique case (phase_q)
            ipdt_pkg::PhLeadMark: begin
              phase_d = ipdt_pkg::PhLeadSpace;
              ticks_d = ipdt_pkg::dur_min1(cfg_i.lead_space);
            end
            ipdt_pkg::PhLeadSpace: begin
              phase_d  = ipdt_pkg::PhBitMark;
              bitpos_d = '0;
              ticks_d  = ipdt_pkg::dur_min1(cfg_i.bit_mark);
            end
            ipdt_pkg::PhBitMark: begin
              phase_d = ipdt_pkg::PhBitSpace;
              ticks_d = ipdt_pkg::dur_min1(cur_bit ? cfg_i.one_space : cfg_i.zero_space);
            end
            ipdt_pkg::PhBitSpace: begin
              if (bitpos_q >= LastBit) begin
                phase_d = ipdt_pkg::PhGap;
                ticks_d = ipdt_pkg::dur_min1(cfg_i.gap);
              end else begin
                bitpos_d = bitpos_q + ipdt_pkg::BitPosW'(1);
                phase_d  = ipdt_pkg::PhBitMark;
                ticks_d  = ipdt_pkg::dur_min1(cfg_i.bit_mark);
              end
            end
            ipdt_pkg::PhGap: begin
              frames_d = frames_inc;
              if (last_frame) begin
                phase_d = ipdt_pkg::PhIdle;
                ticks_d = '0;
              end else begin
                phase_d  = ipdt_pkg::PhLeadMark;
                bitpos_d = '0;
                ticks_d  = ipdt_pkg::dur_min1(cfg_i.lead_mark);
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // result of the current item
  always_comb begin
    result_o.carrier_on = item_valid_i &&
                          (phase_q == ipdt_pkg::PhLeadMark || phase_q == ipdt_pkg::PhBitMark);
    result_o.busy_res   = (phase_d != ipdt_pkg::PhIdle);
    result_o.rejected   = item_valid_i && cmd_i && (phase_q != ipdt_pkg::PhIdle);
    result_o.done_res   = item_valid_i && !cmd_i && (phase_q == ipdt_pkg::PhGap) &&
                          expire && last_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ipdt_pkg::PhIdle;
      ticks_q  <= '0;
      bitpos_q <= '0;
      frames_q <= '0;
      word_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      ticks_q  <= ticks_d;
      bitpos_q <= bitpos_d;
      frames_q <= frames_d;
      word_q   <= word_d;
    end
  end

  `IPDT_ASSERT_IMP(a_idle_no_ticks, phase_q == ipdt_pkg::PhIdle, ticks_q == '0, "idle, ticks")
  `IPDT_ASSERT_IMP(a_busy_has_ticks, phase_q != ipdt_pkg::PhIdle, ticks_q != '0, "no ticks left")
  `IPDT_ASSERT(a_bitpos_range, bitpos_q <= LastBit, "bit position past last bit")
  `IPDT_ASSERT_IMP(a_done_goes_idle, result_o.done_res, phase_d == ipdt_pkg::PhIdle, "done, busy")

endmodule

`default_nettype wire

// File: hw/rtl/ipdt_out_stage.sv
// result register between the sequencer and the output channel
`default_nettype none

`include "assert_macros.svh"

module ipdt_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ipdt_pkg::result_t result_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ipdt_pkg::result_t      result_o
);

  logic              valid_q, valid_d;
  ipdt_pkg::result_t data_q;
  logic              load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  `IPDT_ASSERT_IMP(a_no_overwrite, valid_q && !out_ready_i, !in_ready_o, "held result lost")
  `IPDT_ASSERT_IMP(a_done_not_busy, valid_q && data_q.done_res, !data_q.busy_res, "done, busy")
  `IPDT_ASSERT_IMP(a_ready_when_empty, !valid_q, in_ready_o, "not ready while empty")

endmodule

`default_nettype wire

// File: hw/rtl/ir_pulse_distance_transmitter_unit.sv
// top level of the ir pulse-distance transmitter
//
// usage
//   in_if  : items of cmd and command_bits; cmd 1 starts a frame with the given word
//            (bit 0 first), cmd 0 is one time tick (one microsecond by default)
//   out_if : one result per item: carrier_on for that tick, busy_res after the item,
//            done_res on the last tick of the final gap, rejected for a start while busy
//   cfg    : cfg_we_i / cfg_idx_i / cfg_data_i write the six tick durations and the
//            frame repeat count; write them only while no frame is running
// timing
//   every item takes one cycle through the sequencer logic and lands in the result
//   register, so a result shows one cycle after its item is taken; one item per cycle
//   is taken as long as the result register is empty or being drained
// reset
//   registers go to their default nec timing (9000/4500/562/562/1687/40000 ticks,
//   two frames), the sequencer to idle and the result register to empty
// stall
//   while out_if.ready is low and a result is held, in_if.ready stays low and the
//   sequencer state does not move
`default_nettype none

module ir_pulse_distance_transmitter_unit #(
  parameter int unsigned COMMAND_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ipdt_in_if.sink                            in_if,
  ipdt_out_if.source                         out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [ipdt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ipdt_pkg::CfgDatW-1:0]  cfg_data_i
);

  ipdt_pkg::cfg_t    cfg;
  ipdt_pkg::result_t seq_res;
  ipdt_pkg::result_t out_res;
  logic              in_ready;
  logic              in_fire;

  // an item moves the sequencer only when the result register can take its result
  assign in_fire     = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  ipdt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // phase, tick count, bit position and frame count live here
  ipdt_sequencer #(
    .COMMAND_BITS (COMMAND_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .item_valid_i   (in_fire),
    .cmd_i          (in_if.cmd),
    .command_bits_i (in_if.command_bits),
    .result_o       (seq_res)
  );

  // one-entry result register decouples the two channels
  ipdt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .result_i    (seq_res),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .result_o    (out_res)
  );

  assign out_if.carrier_on = out_res.carrier_on;
  assign out_if.busy_res   = out_res.busy_res;
  assign out_if.done_res   = out_res.done_res;
  assign out_if.rejected   = out_res.rejected;

endmodule

`default_nettype wire
